[rtl/isse_pkg.sv]
`default_nettype none

package isse_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 16;
    localparam int DATA_BITS  = 16;
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [CNT_BITS-1:0]   t_count;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   insert;      // place value in this cycle
        logic   shift_down;  // drain: every cell takes its upper neighbor
        t_value value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[rtl/insertion_sort_engine_unit.sv]
`default_nettype none

// channel   direction  tdata             tuser     tlast
// s         in         value[15:0]       -         last
// m         out        sorted_value      dropped   last_out
//
// Load: one transaction per cycle; each value lands in the cell chain in its
// accepting cycle (one compare per cell, neighbors move up) or drops if full.
// Drain: after a transaction with tlast, input stalls and the list leaves from
// cell 0 as the chain shifts down, one result per cycle while i_m_tready is
// high. Reset empties the chain (valid bits only) and clears the count and
// drop flag.

module insertion_sort_engine_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    input  wire  [isse_pkg::DATA_BITS-1:0] i_s_tdata,   // [15:0] value
    input  wire                            i_s_tlast,   // last
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    output logic [isse_pkg::DATA_BITS-1:0] o_m_tdata,   // [15:0] sorted_value
    output logic                           o_m_tuser,   // [0] dropped
    output logic                           o_m_tlast    // last_out
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic             r_state;
    logic             n_state;
    isse_pkg::t_count r_count;
    isse_pkg::t_count n_count;
    logic             r_overflow;
    logic             n_overflow;

    logic s_xfer;
    logic m_xfer;
    logic full;

    isse_pkg::t_cell_ctrl ctrl;

    logic             w_valid   [isse_pkg::CAPACITY];
    logic             w_greater [isse_pkg::CAPACITY];
    isse_pkg::t_value w_value   [isse_pkg::CAPACITY];

    assign o_s_tready = (r_state == ST_LOAD);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign m_xfer     = o_m_tvalid && i_m_tready;
    assign full       = (r_count == isse_pkg::t_count'(isse_pkg::CAPACITY));

    assign ctrl.insert     = s_xfer && !full;
    assign ctrl.shift_down = m_xfer;
    assign ctrl.value      = isse_pkg::t_value'(i_s_tdata);

    genvar gi;
    generate
        for (gi = 0; gi < isse_pkg::CAPACITY; gi++) begin : g_cell
            logic             lo_valid;
            logic             lo_greater;
            isse_pkg::t_value lo_value;
            logic             up_valid;
            isse_pkg::t_value up_value;

            if (gi == 0) begin : g_bottom
                assign lo_valid   = 1'b1;
                assign lo_greater = 1'b0;
                assign lo_value   = '0;
            end else begin : g_mid_lo
                assign lo_valid   = w_valid[gi-1];
                assign lo_greater = w_greater[gi-1];
                assign lo_value   = w_value[gi-1];
            end

            if (gi == isse_pkg::CAPACITY - 1) begin : g_top
                assign up_valid = 1'b0;
                assign up_value = '0;
            end else begin : g_mid_up
                assign up_valid = w_valid[gi+1];
                assign up_value = w_value[gi+1];
            end

            isse_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_lo_valid   (lo_valid),
                .i_lo_greater (lo_greater),
                .i_lo_value   (lo_value),
                .i_up_valid   (up_valid),
                .i_up_value   (up_value),
                .o_valid      (w_valid[gi]),
                .o_greater    (w_greater[gi]),
                .o_value      (w_value[gi])
            );
        end
    endgenerate

    assign o_m_tvalid = (r_state == ST_DRAIN) && w_valid[0];
    assign o_m_tdata  = isse_pkg::DATA_BITS'(w_value[0]);
    assign o_m_tuser  = r_overflow;
    assign o_m_tlast  = (r_count == isse_pkg::t_count'(1));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_overflow = r_overflow;
        unique case (r_state)
            ST_LOAD: begin
                if (s_xfer) begin
                    if (full) begin
                        n_overflow = 1'b1;
                    end else begin
                        n_count = r_count + isse_pkg::t_count'(1);
                    end
                    if (i_s_tlast) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (m_xfer) begin
                    n_count = r_count - isse_pkg::t_count'(1);
                    if (o_m_tlast) begin
                        n_state    = ST_LOAD;
                        n_overflow = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_count != '0) && w_valid[0])
        else $error("drain with empty chain");

    a_last_enters_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && i_s_tlast) |=> (r_state == ST_DRAIN))
        else $error("list end did not start drain");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= isse_pkg::t_count'(isse_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_final_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_xfer && o_m_tlast) |=> (r_state == ST_LOAD) && !r_overflow && !w_valid[0])
        else $error("chain not empty after final result");

endmodule

`default_nettype wire

[rtl/isse_cell.sv]
`default_nettype none

module isse_cell (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire isse_pkg::t_cell_ctrl i_ctrl,
    input  wire                       i_lo_valid,
    input  wire                       i_lo_greater,
    input  wire isse_pkg::t_value     i_lo_value,
    input  wire                       i_up_valid,
    input  wire isse_pkg::t_value     i_up_value,
    output logic                      o_valid,
    output logic                      o_greater,
    output isse_pkg::t_value          o_value
);

    logic             r_valid;
    logic             n_valid;
    isse_pkg::t_value r_value;
    isse_pkg::t_value n_value;

    assign o_greater = r_valid && (r_value > i_ctrl.value);
    assign o_valid   = r_valid;
    assign o_value   = r_value;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.shift_down) begin
            n_valid = i_up_valid;
            n_value = i_up_value;
        end else if (i_ctrl.insert) begin
            if (i_lo_greater) begin
                // lower neighbor moves up to make room
                n_valid = 1'b1;
                n_value = i_lo_value;
            end else if (i_lo_valid && (o_greater || !r_valid)) begin
                // this is the insertion slot
                n_valid = 1'b1;
                n_value = i_ctrl.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

[test/insertion_sort_engine_unit_tb.sv]
`default_nettype none

module insertion_sort_engine_unit_tb;

    typedef struct packed {
        isse_pkg::t_value value;
        logic             last;
        logic             hold;    // wait for the output side to empty before offering
    } t_list_item;

    typedef struct packed {
        isse_pkg::t_value value;
        logic             last_out;
        logic             dropped;
    } t_sorted_result;

    localparam int CALM_ITEMS = 60;
    localparam int LONG_STALL = 300;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_tvalid;
    logic [isse_pkg::DATA_BITS-1:0] s_tdata;
    logic                           s_tlast;
    logic                           o_s_tready;
    logic                           o_m_tvalid;
    logic                           m_tready;
    logic [isse_pkg::DATA_BITS-1:0] o_m_tdata;
    logic                           o_m_tuser;
    logic                           o_m_tlast;

    t_list_item     pending_q[$];
    t_sorted_result sorted_out_q[$];

    // predictor state
    isse_pkg::t_value list_entries[isse_pkg::CAPACITY];
    int               list_count;
    logic             list_overflow;

    t_list_item     next_item;
    t_sorted_result want;
    int             errors;
    int             accepted;
    int             s_gap;
    int             m_gap;
    int             long_left;
    bit             long_done;
    int             total_items;

    insertion_sort_engine_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // stable insertion; on last, flush the whole list as expected results
    task automatic place_value(input isse_pkg::t_value v, input logic last);
        int pos;
        int k;
        t_sorted_result r;
        if (list_count < isse_pkg::CAPACITY) begin
            pos = list_count;
            while (pos > 0 && list_entries[pos-1] > v) begin
                list_entries[pos] = list_entries[pos-1];
                pos--;
            end
            list_entries[pos] = v;
            list_count++;
        end else begin
            list_overflow = 1'b1;
        end
        if (last) begin
            for (k = 0; k < list_count; k++) begin
                r.value    = list_entries[k];
                r.last_out = (k + 1 == list_count);
                r.dropped  = list_overflow;
                sorted_out_q.push_back(r);
            end
            list_count    = 0;
            list_overflow = 1'b0;
        end
    endtask

    task automatic add_item(input isse_pkg::t_value v, input logic last, input logic hold);
        t_list_item it;
        it.value = v;
        it.last  = last;
        it.hold  = hold;
        pending_q.push_back(it);
        total_items++;
    endtask

    task automatic add_list(input int len, input int mode, input logic hold);
        int               k;
        isse_pkg::t_value v;
        for (k = 0; k < len; k++) begin
            case (mode)
                0: v = isse_pkg::t_value'($urandom);
                1: v = isse_pkg::t_value'($urandom_range(0, 7));   // heavy duplicates
                2: v = ($urandom_range(0, 2) == 0) ? isse_pkg::t_value'(0) :
                       ($urandom_range(0, 1) == 0) ? isse_pkg::t_value'(16'hffff) :
                                                     isse_pkg::t_value'($urandom);
                default: v = isse_pkg::t_value'(16'hffff - k * 997);  // descending run, wrapping around after k = 65
            endcase
            add_item(v, k == len - 1, hold && k == 0);
        end
    endtask

    initial begin
        int len;
        int r;
        list_count    = 0;
        list_overflow = 1'b0;
        errors        = 0;
        accepted      = 0;
        s_gap         = 0;
        m_gap         = 0;
        long_left     = 0;
        long_done     = 1'b0;
        total_items   = 0;

        // single-entry lists at both ends of the range
        add_item(16'h0000, 1'b1, 1'b0);
        add_item(16'hffff, 1'b1, 1'b0);
        // repeated values
        add_item(16'h0005, 1'b0, 1'b0);
        add_item(16'hffff, 1'b0, 1'b0);
        add_item(16'h0000, 1'b0, 1'b0);
        add_item(16'h0005, 1'b0, 1'b0);
        add_item(16'h0001, 1'b1, 1'b0);
        // strictly descending: every insert shifts the whole chain
        add_item(16'hffff, 1'b0, 1'b0);
        add_item(16'hc000, 1'b0, 1'b0);
        add_item(16'h8000, 1'b0, 1'b0);
        add_item(16'h7fff, 1'b0, 1'b0);
        add_item(16'h4000, 1'b0, 1'b0);
        add_item(16'h00ff, 1'b0, 1'b0);
        add_item(16'h0001, 1'b0, 1'b0);
        add_item(16'h0000, 1'b1, 1'b0);
        add_item(16'haaaa, 1'b0, 1'b0);
        add_item(16'h5555, 1'b1, 1'b0);

        // exactly full, one over (the last item itself is dropped), then three over
        add_list(isse_pkg::CAPACITY, 0, 1'b1);
        add_list(isse_pkg::CAPACITY + 1, 2, 1'b0);
        add_list(isse_pkg::CAPACITY + 3, 1, 1'b0);

        while (total_items < 480) begin
            r = $urandom_range(0, 19);
            if (r == 0)
                len = $urandom_range(isse_pkg::CAPACITY - 1, isse_pkg::CAPACITY + 6);
            else if (r < 3)
                len = $urandom_range(17, isse_pkg::CAPACITY - 2);
            else
                len = $urandom_range(1, 16);
            add_list(len, $urandom_range(0, 3), $urandom_range(0, 24) == 0);
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                place_value(isse_pkg::t_value'(s_tdata), s_tlast);
                accepted++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() > 0 &&
                             !(pending_q[0].hold && sorted_out_q.size() != 0)) begin
                    next_item = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= isse_pkg::DATA_BITS'(next_item.value);
                    s_tlast  <= next_item.last;
                    if (pending_q.size() >= CALM_ITEMS && $urandom_range(0, 9) == 0)
                        s_gap = $urandom_range(1, 19);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (sorted_out_q.size() == 0) begin
                    $display("%0t: unexpected transaction data=%h dropped=%b last=%b",
                             $time, o_m_tdata, o_m_tuser, o_m_tlast);
                    errors++;
                end else begin
                    want = sorted_out_q.pop_front();
                    if (o_m_tdata !== isse_pkg::DATA_BITS'(want.value)) begin
                        $display("%0t: sorted_value expected %h actual %h",
                                 $time, want.value, o_m_tdata);
                        errors++;
                    end
                    if (o_m_tlast !== want.last_out) begin
                        $display("%0t: last_out expected %b actual %b",
                                 $time, want.last_out, o_m_tlast);
                        errors++;
                    end
                    if (o_m_tuser !== want.dropped) begin
                        $display("%0t: dropped expected %b actual %b",
                                 $time, want.dropped, o_m_tuser);
                        errors++;
                    end
                end
            end
            // one long hold-off mid-drain while the sender keeps offering
            if (!long_done && accepted >= 40 && sorted_out_q.size() > 0) begin
                long_left = LONG_STALL;
                long_done = 1'b1;
            end
            if (long_left > 0) begin
                long_left--;
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (pending_q.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0)
                    m_gap = $urandom_range(1, 19);
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        @(posedge i_clk);
        while (pending_q.size() != 0 || s_tvalid || sorted_out_q.size() != 0)
            @(posedge i_clk);
        repeat (2 * isse_pkg::CAPACITY) @(posedge i_clk);
        if (errors == 0 && sorted_out_q.size() == 0)
            $display("insertion_sort_engine_unit_tb: clean");
        else
            $display("insertion_sort_engine_unit_tb: errors");
        $finish;
    end

    initial begin
        #400000;
        $display("insertion_sort_engine_unit_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/isse_pkg.sv
rtl/isse_cell.sv
rtl/insertion_sort_engine_unit.sv
test/insertion_sort_engine_unit_tb.sv
